/* rtl/rqsi_pkg.sv */
package rqsi_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int OCC_W = 5;

   localparam logic [1:0] MODE_FIFO = 2'd0;
   localparam logic [1:0] MODE_SJF  = 2'd1;
   localparam logic [1:0] MODE_PRIO = 2'd2;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [1:0] ST_ENQ   = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_DEQ   = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic        op;
      logic [7:0]  proc_id;
      logic [7:0]  proc_priority;
      logic [15:0] burst_time;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       out_id;
      logic [7:0]       out_priority;
      logic [15:0]      out_time;
      logic [OCC_W-1:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  priority_val;
      logic [15:0] burst;
   } entry_type;

   // insert wave moving down the cell row
   typedef struct packed {
      logic      valid;
      logic      shift;   // already displaced something: push unconditionally
      entry_type entry;
   } tok_type;

   // true when the new record must stand ahead of the held one
   function automatic logic outranks(input logic [1:0] mode, input entry_type nw,
                                     input entry_type held);
      logic res;
      res = 1'b0;
      unique case (mode)
         MODE_SJF:  res = held.burst > nw.burst;
         MODE_PRIO: res = held.priority_val < nw.priority_val;
         default:   res = 1'b0;
      endcase
      return res;
   endfunction

endpackage

/* rtl/rqsi_cell.sv */
module rqsi_cell
   import rqsi_pkg::*;
#(
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       mode,
   input  tok_type          tin,
   input  logic [CNT_W-1:0] tin_left,
   input  logic             shift_left,
   input  entry_type        right_entry,
   output entry_type        entry_out,
   output tok_type          tout,
   output logic [CNT_W-1:0] tout_left,
   output logic             absorb
);

   entry_type        entry_ff, entry_in;
   tok_type          tok_ff, tok_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             at_tail, take;

   // at_tail: this cell is the first free slot, the wave ends here
   assign at_tail = (tin_left == '0);
   assign take    = at_tail || tin.shift || outranks(mode, tin.entry, entry_ff);
   assign absorb  = tin.valid && at_tail;

   always_comb begin
      entry_in = entry_ff;
      if (tin.valid) begin
         if (take) entry_in = tin.entry;
      end else if (shift_left) begin
         entry_in = right_entry;
      end
      tok_in.valid = tin.valid && !at_tail;
      tok_in.shift = tin.shift || take;
      tok_in.entry = take ? entry_ff : tin.entry;
      left_in      = tin_left - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      left_ff  <= left_in;
      tok_ff.shift <= tok_in.shift;
      tok_ff.entry <= tok_in.entry;
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
   end

   assign entry_out = entry_ff;
   assign tout      = tok_ff;
   assign tout_left = left_ff;

endmodule

/* rtl/ready_queue_sorted_insert.sv */
// Sorted ready queue built as a row of cells, head in cell 0.
// Input channel req_*: valid/ready, one item per handshake; op selects
// enqueue of the carried process or dequeue of the head entry.
// Result channel rsp_*: valid/ready, exactly one result per item, held in an
// output register; it appears the cycle after the item is accepted.
// csr_we/csr_wdata write the queue mode (fifo, shortest time, priority).
// A dequeue does not hold off the next item. An enqueue starts a wave that moves
// one cell per cycle down the row to the current tail, and no new item is
// accepted until the wave has ended there. A full-queue enqueue or
// empty-queue dequeue starts no wave and does not hold off the next item.
// While the receiver stalls with a result pending, no new item is taken;
// the pending result holds until rsp_ready.
// Reset (synchronous) empties the queue, sets fifo mode and clears any
// pending result; entry contents are not cleared.
module ready_queue_sorted_insert
   import rqsi_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [1:0]       mode_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   tok_type          tok     [QUEUE_DEPTH+1];
   logic [CNT_W-1:0] tok_left[QUEUE_DEPTH+1];
   entry_type        ent     [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] absorb;

   logic      accept, is_full, is_empty, launch, pop;
   entry_type new_entry;

   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign launch    = accept && (req_data.op == OP_ENQ) && !is_full;
   assign pop       = accept && (req_data.op == OP_DEQ) && !is_empty;

   assign new_entry.id           = req_data.proc_id;
   assign new_entry.priority_val = req_data.proc_priority;
   assign new_entry.burst        = req_data.burst_time;

   assign tok[0].valid = launch;
   assign tok[0].shift = 1'b0;
   assign tok[0].entry = new_entry;
   assign tok_left[0]  = count_ff;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type right;
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right = ent[i];
      end else begin : g_mid
         assign right = ent[i+1];
      end
      rqsi_cell #(.CNT_W(CNT_W)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .mode        (mode_ff),
         .tin         (tok[i]),
         .tin_left    (tok_left[i]),
         .shift_left  (pop),
         .right_entry (right),
         .entry_out   (ent[i]),
         .tout        (tok[i+1]),
         .tout_left   (tok_left[i+1]),
         .absorb      (absorb[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (launch) count_in = count_ff + CNT_W'(1);
      else if (pop) count_in = count_ff - CNT_W'(1);

      busy_in = busy_ff;
      if (|absorb) busy_in = 1'b0;
      else if (launch) busy_in = 1'b1;

      rsp_in.out_id       = '0;
      rsp_in.out_priority = '0;
      rsp_in.out_time     = '0;
      rsp_in.occupancy    = OCC_W'(count_in);
      if (req_data.op == OP_ENQ) begin
         rsp_in.status = is_full ? ST_FULL : ST_ENQ;
      end else if (is_empty) begin
         rsp_in.status = ST_EMPTY;
      end else begin
         rsp_in.status       = ST_DEQ;
         rsp_in.out_id       = ent[0].id;
         rsp_in.out_priority = ent[0].priority_val;
         rsp_in.out_time     = ent[0].burst;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
      if (reset) begin
         mode_ff      <= MODE_FIFO;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) mode_ff <= csr_wdata;
         count_ff <= count_in;
         busy_ff  <= busy_in;
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_wave_in_row: assert property (@(posedge clock) disable iff (reset)
      !tok[QUEUE_DEPTH].valid)
      else $error("insert wave ran past the last cell");

   a_absorb_once: assert property (@(posedge clock) disable iff (reset)
      $onehot0(absorb))
      else $error("more than one cell took the wave end");

   a_absorb_busy: assert property (@(posedge clock) disable iff (reset)
      (|absorb) |-> (busy_ff || launch))
      else $error("wave ended with no insert in flight");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !busy_ff && count_ff == '0))
      else $error("state not cleared by reset");

endmodule
